// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion with an explicit clock and active-low reset.
`define WFE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the default clk_i / rst_ni pair.
`define WFE_ASSERT(lbl, prop, msg) \
  `WFE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: src/wfe_pkg.sv
// ----------------------------------------------------------------------------
// wfe_pkg
// Constants, types and helpers for the WalkSAT flip engine.
// ----------------------------------------------------------------------------
`default_nettype none

package wfe_pkg;

  localparam int LITS_PER_CLAUSE = 3;
  localparam int MAX_VARS        = 1024;
  localparam int MAX_CLAUSES     = 4096;
  localparam int MAX_OCCURRENCES = 32;

  // port field widths
  localparam int CMD_W   = 3;
  localparam int CIDX_W  = 12;
  localparam int SLOT_W  = 2;
  localparam int VAR_W   = 11;
  localparam int PICK_W  = 16;
  localparam int NOISE_W = 10;
  localparam int CCNT_W  = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // internal widths
  localparam int KW   = $clog2(LITS_PER_CLAUSE);
  localparam int VW   = $clog2(MAX_VARS);
  localparam int CW   = $clog2(MAX_CLAUSES);
  localparam int OW   = $clog2(MAX_OCCURRENCES);
  localparam int OCW  = $clog2(MAX_OCCURRENCES + 1);
  localparam int TW   = $clog2(LITS_PER_CLAUSE + 1);
  localparam int LENW = $clog2(MAX_CLAUSES + 1);
  localparam int CTAW = $clog2(MAX_CLAUSES * LITS_PER_CLAUSE);
  localparam int OTAW = VW + OW;
  localparam int DIVW = $clog2(PICK_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 3'd0,
    CMD_SET   = 3'd1,
    CMD_START = 3'd2,
    CMD_FLIP  = 3'd3,
    CMD_READ  = 3'd4
  } wfe_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLAUSE_COUNT = 1'b0,
    CFG_NOISE        = 1'b1
  } wfe_cfg_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_LD_RD, ST_LD_WR, ST_RD_A,
    ST_TRY_C, ST_TRY_L, ST_TRY_V, ST_TRY_A, ST_TRY_W,
    ST_DIV, ST_FL_PICK, ST_FL_CL, ST_FL_LIT, ST_FL_VAR, ST_FL_N,
    ST_FL_K, ST_FL_O, ST_FL_T, ST_FL_SCORE, ST_FL_NOISE, ST_FL_NZ,
    ST_UP_V, ST_UP_N, ST_UP_K, ST_UP_O, ST_UP_T, ST_UP_L, ST_UP_E,
    ST_FLIP, ST_FIN
  } wfe_state_e;

  typedef struct packed {
    logic [VW-1:0] var0;
    logic          neg;
  } wfe_lit_t;

  typedef struct packed {
    logic [CW-1:0] clause;
    logic          neg;
  } wfe_occ_t;

  typedef struct packed {
    wfe_state_e op;
    logic       accept;
  } wfe_ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic load_ok;
    logic len_zero;
    logic c_done;
    logic c_active;
    logic l_last;
    logic k_done;
    logic div_last;
    logic noise_hit;
    logic erase_need;
    logic clr_last;
    logic out_free;
  } wfe_ctrl_sts_t;

  function automatic logic [CTAW-1:0] ct_addr(logic [CW-1:0] c, logic [KW-1:0] l);
    return CTAW'(c) * CTAW'(LITS_PER_CLAUSE) + CTAW'(l);
  endfunction

endpackage

`default_nettype wire

// File: src/wfe_ctrl.sv
// ----------------------------------------------------------------------------
// wfe_ctrl
// Sequencer for the flip engine: steps the datapath through each command.
// ----------------------------------------------------------------------------
`default_nettype none

module wfe_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  wfe_pkg::wfe_ctrl_sts_t sts_i,
  output wfe_pkg::wfe_ctrl_cmd_t cmd_o
);
  import wfe_pkg::*;

  wfe_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    in_ready_o   = (state_q == ST_IDLE);
    cmd_o.op     = state_q;
    cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
    case (state_q)
      ST_CLEAR:    if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:     if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: begin
        case (sts_i.cmd)
          CMD_LOAD:  state_d = sts_i.load_ok ? ST_LD_RD : ST_FIN;
          CMD_START: state_d = ST_TRY_C;
          CMD_FLIP:  state_d = sts_i.len_zero ? ST_FIN : ST_DIV;
          CMD_READ:  state_d = ST_RD_A;
          default:   state_d = ST_FIN;
        endcase
      end
      ST_LD_RD:    state_d = ST_LD_WR;
      ST_LD_WR:    state_d = ST_FIN;
      ST_RD_A:     state_d = ST_FIN;
      ST_TRY_C: begin
        if (sts_i.c_done) state_d = ST_FIN;
        else if (sts_i.c_active) state_d = ST_TRY_L;
      end
      ST_TRY_L:    state_d = ST_TRY_V;
      ST_TRY_V:    state_d = ST_TRY_A;
      ST_TRY_A:    state_d = sts_i.l_last ? ST_TRY_W : ST_TRY_L;
      ST_TRY_W:    state_d = ST_TRY_C;
      ST_DIV:      if (sts_i.div_last) state_d = ST_FL_PICK;
      ST_FL_PICK:  state_d = ST_FL_CL;
      ST_FL_CL:    state_d = ST_FL_LIT;
      ST_FL_LIT:   state_d = ST_FL_VAR;
      ST_FL_VAR:   state_d = ST_FL_N;
      ST_FL_N:     state_d = ST_FL_K;
      ST_FL_K:     state_d = sts_i.k_done ? ST_FL_SCORE : ST_FL_O;
      ST_FL_O:     state_d = ST_FL_T;
      ST_FL_T:     state_d = ST_FL_K;
      ST_FL_SCORE: state_d = sts_i.l_last ? ST_FL_NOISE : ST_FL_LIT;
      ST_FL_NOISE: state_d = sts_i.noise_hit ? ST_FL_NZ : ST_UP_V;
      ST_FL_NZ:    state_d = ST_UP_V;
      ST_UP_V:     state_d = ST_UP_N;
      ST_UP_N:     state_d = ST_UP_K;
      ST_UP_K:     state_d = sts_i.k_done ? ST_FLIP : ST_UP_O;
      ST_UP_O:     state_d = ST_UP_T;
      ST_UP_T:     state_d = ST_UP_L;
      ST_UP_L:     state_d = sts_i.erase_need ? ST_UP_E : ST_UP_K;
      ST_UP_E:     state_d = ST_UP_K;
      ST_FLIP:     state_d = ST_FIN;
      ST_FIN:      if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: src/wfe_datapath.sv
// ----------------------------------------------------------------------------
// wfe_datapath
// Clause/occurrence tables, costs, unsatisfied list and the working registers.
// ----------------------------------------------------------------------------
`default_nettype none

module wfe_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wfe_pkg::wfe_ctrl_cmd_t              cmd_i,
  output wfe_pkg::wfe_ctrl_sts_t              sts_o,
  input  logic                                cfg_we_i,
  input  logic [wfe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wfe_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [wfe_pkg::CMD_W-1:0]           cmd_field_i,
  input  logic [wfe_pkg::CIDX_W-1:0]          clause_index_i,
  input  logic [wfe_pkg::SLOT_W-1:0]          slot_i,
  input  logic [wfe_pkg::VAR_W-1:0]           variable_i,
  input  logic                                negated_i,
  input  logic                                bit_value_i,
  input  logic [wfe_pkg::PICK_W-1:0]          rand_pick_i,
  input  logic [wfe_pkg::NOISE_W-1:0]         rand_noise_i,
  input  logic [wfe_pkg::SLOT_W-1:0]          rand_slot_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wfe_pkg::VAR_W-1:0]           flipped_var_o,
  output logic                                read_bit_o,
  output logic [wfe_pkg::CCNT_W-1:0]          unsat_count_o,
  output logic                                solved_o,
  output logic                                status_o
);
  import wfe_pkg::*;

  // memories
  wfe_lit_t       ct_mem   [MAX_CLAUSES*LITS_PER_CLAUSE];
  wfe_occ_t       occ_mem  [MAX_VARS*MAX_OCCURRENCES];
  logic [OCW-1:0] cnt_mem  [MAX_VARS];
  logic           a_mem    [MAX_VARS];
  logic [TW-1:0]  tlc_mem  [MAX_CLAUSES];
  logic [CW-1:0]  list_mem [MAX_CLAUSES];
  logic [CW-1:0]  pos_mem  [MAX_CLAUSES];

  logic ct_we, ct_re, occ_we, occ_re, cnt_we, cnt_re, a_we, a_re;
  logic tlc_we, tlc_re, list_we, list_re, pos_we, pos_re;
  logic [CTAW-1:0] ct_waddr, ct_raddr;
  logic [OTAW-1:0] occ_waddr, occ_raddr;
  logic [VW-1:0]   cnt_waddr, cnt_raddr, a_waddr, a_raddr;
  logic [CW-1:0]   tlc_waddr, tlc_raddr, list_waddr, list_raddr, pos_waddr, pos_raddr;
  wfe_lit_t        ct_wdata, ct_rdata_q;
  wfe_occ_t        occ_wdata, occ_rdata_q;
  logic [OCW-1:0]  cnt_wdata, cnt_rdata_q;
  logic            a_wdata, a_rdata_q;
  logic [TW-1:0]   tlc_wdata, tlc_rdata_q;
  logic [CW-1:0]   list_wdata, list_rdata_q, pos_wdata, pos_rdata_q;

  // latched item
  logic [CMD_W-1:0]   cmd_q;
  logic [CIDX_W-1:0]  ci_q;
  logic [SLOT_W-1:0]  slot_q, rslot_q;
  logic [VAR_W-1:0]   var_q;
  logic               neg_q, bit_q;
  logic [PICK_W-1:0]  pick_q;
  logic [NOISE_W-1:0] rnoise_q;

  // control registers
  logic [CCNT_W-1:0]  cc_q;
  logic [NOISE_W-1:0] npm_q;
  logic [LENW-1:0]    len_q;
  logic [VW-1:0]      clr_q;
  logic               out_valid_q;

  // working registers
  logic [LENW-1:0] r_q, c_q;
  logic [DIVW-1:0] dcnt_q;
  logic [CW-1:0]   cl_q, p_q;
  logic [KW-1:0]   l_q;
  logic [OCW-1:0]  k_q, n_q, brk_q, mk_q, bmin_q, mmax_q;
  logic [VW-1:0]   v_q, best_q;
  logic            a_q, oneg_q;
  logic [TW-1:0]   cost_q;
  logic [VAR_W-1:0] flipped_q;
  logic             status_q;

  // output registers
  logic [VAR_W-1:0]  out_flip_q;
  logic              out_rbit_q, out_status_q;
  logic [CCNT_W-1:0] out_len_q;

  logic [VW-1:0]   vin0;
  logic            var_ok, lit_true, inlist, insert, better, out_free;
  logic [LENW-1:0] n_eff, rsh, rstep;
  logic [KW-1:0]   rs_mod;
  logic [TW-1:0]   tlc_next;

  assign vin0     = VW'(var_q - VAR_W'(1));
  assign var_ok   = (var_q != '0) && (32'(var_q) <= MAX_VARS);
  assign n_eff    = (32'(cc_q) > MAX_CLAUSES) ? LENW'(MAX_CLAUSES) : LENW'(cc_q);
  assign rsh      = {r_q[LENW-2:0], pick_q[dcnt_q]};
  assign rstep    = (rsh >= len_q) ? rsh - len_q : rsh;
  assign rs_mod   = (32'(rslot_q) >= LITS_PER_CLAUSE)
                    ? KW'(32'(rslot_q) - LITS_PER_CLAUSE) : KW'(rslot_q);
  assign lit_true = a_q ^ oneg_q;
  // list membership: position table is only trusted when it points back at c
  assign inlist   = ({1'b0, p_q} < len_q) && (list_rdata_q == c_q[CW-1:0]);
  assign insert   = lit_true && (cost_q == TW'(1)) && !inlist
                    && (32'(len_q) < MAX_CLAUSES);
  assign tlc_next = lit_true ? ((cost_q == '0) ? cost_q : cost_q - TW'(1))
                             : ((32'(cost_q) == LITS_PER_CLAUSE) ? cost_q
                                                                 : cost_q + TW'(1));
  assign better   = (l_q == '0) || (brk_q < bmin_q)
                    || ((brk_q == bmin_q) && (mk_q > mmax_q));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.cmd        = cmd_q;
    sts_o.load_ok    = var_ok && (32'(ci_q) < MAX_CLAUSES)
                       && (32'(slot_q) < LITS_PER_CLAUSE);
    sts_o.len_zero   = (len_q == '0);
    sts_o.c_done     = (32'(c_q) == MAX_CLAUSES);
    sts_o.c_active   = (c_q < n_eff);
    sts_o.l_last     = (32'(l_q) == LITS_PER_CLAUSE - 1);
    sts_o.k_done     = (k_q == n_q);
    sts_o.div_last   = (dcnt_q == '0);
    sts_o.noise_hit  = (rnoise_q < npm_q);
    sts_o.erase_need = !lit_true && (cost_q == '0) && inlist;
    sts_o.clr_last   = (32'(clr_q) == MAX_VARS - 1);
    sts_o.out_free   = out_free;
  end

  // memory port control
  always_comb begin
    ct_we = 1'b0; ct_re = 1'b0; occ_we = 1'b0; occ_re = 1'b0;
    cnt_we = 1'b0; cnt_re = 1'b0; a_we = 1'b0; a_re = 1'b0;
    tlc_we = 1'b0; tlc_re = 1'b0; list_we = 1'b0; list_re = 1'b0;
    pos_we = 1'b0; pos_re = 1'b0;
    ct_waddr = '0; ct_raddr = '0; occ_waddr = '0; occ_raddr = '0;
    cnt_waddr = '0; cnt_raddr = '0; a_waddr = '0; a_raddr = '0;
    tlc_waddr = '0; tlc_raddr = '0; list_waddr = '0; list_raddr = '0;
    pos_waddr = '0; pos_raddr = '0;
    ct_wdata = '0; occ_wdata = '0; cnt_wdata = '0; a_wdata = 1'b0;
    tlc_wdata = '0; list_wdata = '0; pos_wdata = '0;
    case (cmd_i.op)
      ST_CLEAR: begin
        cnt_we = 1'b1; cnt_waddr = clr_q;
        a_we   = 1'b1; a_waddr   = clr_q;
      end
      ST_DECODE: begin
        if (cmd_q == CMD_SET && var_ok) begin
          a_we = 1'b1; a_waddr = vin0; a_wdata = bit_q;
        end
      end
      ST_LD_RD: begin
        cnt_re = 1'b1; cnt_raddr = vin0;
      end
      ST_LD_WR: begin
        ct_we    = 1'b1;
        ct_waddr = ct_addr(CW'(ci_q), KW'(slot_q));
        ct_wdata = '{var0: vin0, neg: neg_q};
        if (32'(cnt_rdata_q) < MAX_OCCURRENCES) begin
          occ_we    = 1'b1;
          occ_waddr = {vin0, cnt_rdata_q[OW-1:0]};
          occ_wdata = '{clause: CW'(ci_q), neg: neg_q};
          cnt_we    = 1'b1;
          cnt_waddr = vin0;
          cnt_wdata = cnt_rdata_q + OCW'(1);
        end
      end
      ST_RD_A: begin
        a_re = 1'b1; a_raddr = vin0;
      end
      ST_TRY_C: begin
        if (!sts_o.c_done && !sts_o.c_active) begin
          tlc_we = 1'b1; tlc_waddr = c_q[CW-1:0];
        end
      end
      ST_TRY_L: begin
        ct_re = 1'b1; ct_raddr = ct_addr(c_q[CW-1:0], l_q);
      end
      ST_TRY_V: begin
        a_re = 1'b1; a_raddr = ct_rdata_q.var0;
      end
      ST_TRY_W: begin
        tlc_we = 1'b1; tlc_waddr = c_q[CW-1:0]; tlc_wdata = cost_q;
        if (cost_q == '0) begin
          list_we = 1'b1; list_waddr = len_q[CW-1:0]; list_wdata = c_q[CW-1:0];
          pos_we  = 1'b1; pos_waddr  = c_q[CW-1:0];   pos_wdata  = len_q[CW-1:0];
        end
      end
      ST_FL_PICK: begin
        list_re = 1'b1; list_raddr = r_q[CW-1:0];
      end
      ST_FL_LIT: begin
        ct_re = 1'b1; ct_raddr = ct_addr(cl_q, l_q);
      end
      ST_FL_VAR: begin
        cnt_re = 1'b1; cnt_raddr = ct_rdata_q.var0;
        a_re   = 1'b1; a_raddr   = ct_rdata_q.var0;
      end
      ST_FL_K: begin
        if (!sts_o.k_done) begin
          occ_re = 1'b1; occ_raddr = {v_q, k_q[OW-1:0]};
        end
      end
      ST_FL_O: begin
        tlc_re = 1'b1; tlc_raddr = occ_rdata_q.clause;
      end
      ST_FL_NOISE: begin
        if (sts_o.noise_hit) begin
          ct_re = 1'b1; ct_raddr = ct_addr(cl_q, rs_mod);
        end
      end
      ST_UP_V: begin
        cnt_re = 1'b1; cnt_raddr = best_q;
        a_re   = 1'b1; a_raddr   = best_q;
      end
      ST_UP_K: begin
        if (!sts_o.k_done) begin
          occ_re = 1'b1; occ_raddr = {best_q, k_q[OW-1:0]};
        end
      end
      ST_UP_O: begin
        tlc_re = 1'b1; tlc_raddr = occ_rdata_q.clause;
        pos_re = 1'b1; pos_raddr = occ_rdata_q.clause;
      end
      ST_UP_T: begin
        list_re = 1'b1; list_raddr = pos_rdata_q;
      end
      ST_UP_L: begin
        tlc_we = 1'b1; tlc_waddr = c_q[CW-1:0]; tlc_wdata = tlc_next;
        if (insert) begin
          list_we = 1'b1; list_waddr = len_q[CW-1:0]; list_wdata = c_q[CW-1:0];
          pos_we  = 1'b1; pos_waddr  = c_q[CW-1:0];   pos_wdata  = len_q[CW-1:0];
        end
        if (sts_o.erase_need) begin
          list_re = 1'b1; list_raddr = CW'(len_q - LENW'(1));
        end
      end
      ST_UP_E: begin
        // move the last entry into the vacated slot
        list_we = 1'b1; list_waddr = p_q;          list_wdata = list_rdata_q;
        pos_we  = 1'b1; pos_waddr  = list_rdata_q; pos_wdata  = p_q;
      end
      ST_FLIP: begin
        a_we = 1'b1; a_waddr = best_q; a_wdata = ~a_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ct_we)   ct_mem[ct_waddr]     <= ct_wdata;
    if (ct_re)   ct_rdata_q           <= ct_mem[ct_raddr];
    if (occ_we)  occ_mem[occ_waddr]   <= occ_wdata;
    if (occ_re)  occ_rdata_q          <= occ_mem[occ_raddr];
    if (cnt_we)  cnt_mem[cnt_waddr]   <= cnt_wdata;
    if (cnt_re)  cnt_rdata_q          <= cnt_mem[cnt_raddr];
    if (a_we)    a_mem[a_waddr]       <= a_wdata;
    if (a_re)    a_rdata_q            <= a_mem[a_raddr];
    if (tlc_we)  tlc_mem[tlc_waddr]   <= tlc_wdata;
    if (tlc_re)  tlc_rdata_q          <= tlc_mem[tlc_raddr];
    if (list_we) list_mem[list_waddr] <= list_wdata;
    if (list_re) list_rdata_q         <= list_mem[list_raddr];
    if (pos_we)  pos_mem[pos_waddr]   <= pos_wdata;
    if (pos_re)  pos_rdata_q          <= pos_mem[pos_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q        <= CCNT_W'(1);
      npm_q       <= '0;
      len_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CLAUSE_COUNT: cc_q  <= cfg_data_i[CCNT_W-1:0];
          CFG_NOISE:        npm_q <= cfg_data_i[NOISE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == ST_CLEAR) clr_q <= clr_q + VW'(1);
      case (cmd_i.op)
        ST_DECODE: if (cmd_q == CMD_START) len_q <= '0;
        ST_TRY_W:  if (cost_q == '0) len_q <= len_q + LENW'(1);
        ST_UP_L:   if (insert) len_q <= len_q + LENW'(1);
        ST_UP_E:   len_q <= len_q - LENW'(1);
        default: ;
      endcase
      if (cmd_i.op == ST_FIN && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q    <= cmd_field_i;
      ci_q     <= clause_index_i;
      slot_q   <= slot_i;
      var_q    <= variable_i;
      neg_q    <= negated_i;
      bit_q    <= bit_value_i;
      pick_q   <= rand_pick_i;
      rnoise_q <= rand_noise_i;
      rslot_q  <= rand_slot_i;
    end
    case (cmd_i.op)
      ST_DECODE: begin
        flipped_q <= '0;
        status_q  <= 1'b0;
        r_q       <= '0;
        dcnt_q    <= DIVW'(PICK_W - 1);
        c_q       <= '0;
      end
      ST_LD_WR: status_q <= (32'(cnt_rdata_q) >= MAX_OCCURRENCES);
      ST_TRY_C: begin
        if (!sts_o.c_done && !sts_o.c_active) c_q <= c_q + LENW'(1);
        l_q    <= '0;
        cost_q <= '0;
      end
      ST_TRY_V: oneg_q <= ct_rdata_q.neg;
      ST_TRY_A: begin
        if (a_rdata_q ^ oneg_q) cost_q <= cost_q + TW'(1);
        l_q <= l_q + KW'(1);
      end
      ST_TRY_W: c_q <= c_q + LENW'(1);
      ST_DIV: begin
        r_q    <= rstep;
        dcnt_q <= dcnt_q - DIVW'(1);
      end
      ST_FL_CL: begin
        cl_q <= list_rdata_q;
        l_q  <= '0;
      end
      ST_FL_VAR: begin
        v_q   <= ct_rdata_q.var0;
        brk_q <= '0;
        mk_q  <= '0;
        k_q   <= '0;
      end
      ST_FL_N, ST_UP_N: begin
        n_q <= cnt_rdata_q;
        a_q <= a_rdata_q;
      end
      ST_FL_O: oneg_q <= occ_rdata_q.neg;
      ST_FL_T: begin
        if (a_q ^ oneg_q) begin
          if (tlc_rdata_q == TW'(1)) brk_q <= brk_q + OCW'(1);
        end else if (tlc_rdata_q == '0) begin
          mk_q <= mk_q + OCW'(1);
        end
        k_q <= k_q + OCW'(1);
      end
      ST_FL_SCORE: begin
        if (better) begin
          bmin_q <= brk_q;
          mmax_q <= mk_q;
          best_q <= v_q;
        end
        l_q <= l_q + KW'(1);
      end
      ST_FL_NZ: best_q <= ct_rdata_q.var0;
      ST_UP_V:  k_q <= '0;
      ST_UP_O: begin
        c_q    <= LENW'(occ_rdata_q.clause);
        oneg_q <= occ_rdata_q.neg;
      end
      ST_UP_T: begin
        cost_q <= tlc_rdata_q;
        p_q    <= pos_rdata_q;
      end
      ST_UP_L: k_q <= k_q + OCW'(1);
      ST_FLIP: flipped_q <= VAR_W'(best_q) + VAR_W'(1);
      ST_FIN: begin
        if (out_free) begin
          out_flip_q   <= flipped_q;
          out_rbit_q   <= (cmd_q == CMD_READ) && var_ok && a_rdata_q;
          out_len_q    <= CCNT_W'(len_q);
          out_status_q <= status_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign flipped_var_o = out_flip_q;
  assign read_bit_o    = out_rbit_q;
  assign unsat_count_o = out_len_q;
  assign solved_o      = (out_len_q == '0);
  assign status_o      = out_status_q;

endmodule

`default_nettype wire

// File: src/walksat_flip_engine.sv
// Load reads, then updates the occurrence count; set and read access the assignment table.
// Start try: scans clause slots up to MAX_CLAUSES, counting true literals of clauses in use.
// Flip: scores each literal of the picked clause, then updates the best variable's clauses.
// One item at a time; each result waits while the output is stalled.
// After reset a pass clears the occurrence counts and assignment, with in_ready_o low.
// ----------------------------------------------------------------------------
// walksat_flip_engine
// WalkSAT local search core: clause loading, try setup and scored flips.
// ----------------------------------------------------------------------------
`default_nettype none

module walksat_flip_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wfe_pkg::CMD_W-1:0]      cmd_i,
  input  logic [wfe_pkg::CIDX_W-1:0]     clause_index_i,
  input  logic [wfe_pkg::SLOT_W-1:0]     slot_i,
  input  logic [wfe_pkg::VAR_W-1:0]      variable_i,
  input  logic                           negated_i,
  input  logic                           bit_value_i,
  input  logic [wfe_pkg::PICK_W-1:0]     rand_pick_i,
  input  logic [wfe_pkg::NOISE_W-1:0]    rand_noise_i,
  input  logic [wfe_pkg::SLOT_W-1:0]     rand_slot_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wfe_pkg::VAR_W-1:0]      flipped_var_o,
  output logic                           read_bit_o,
  output logic [wfe_pkg::CCNT_W-1:0]     unsat_count_o,
  output logic                           solved_o,
  output logic                           status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wfe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wfe_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wfe_pkg::*;

  wfe_ctrl_cmd_t ctrl_cmd;
  wfe_ctrl_sts_t ctrl_sts;

  assign cfg_ready_o = 1'b1;

  wfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  wfe_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .sts_o          (ctrl_sts),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_field_i    (cmd_i),
    .clause_index_i (clause_index_i),
    .slot_i         (slot_i),
    .variable_i     (variable_i),
    .negated_i      (negated_i),
    .bit_value_i    (bit_value_i),
    .rand_pick_i    (rand_pick_i),
    .rand_noise_i   (rand_noise_i),
    .rand_slot_i    (rand_slot_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .flipped_var_o  (flipped_var_o),
    .read_bit_o     (read_bit_o),
    .unsat_count_o  (unsat_count_o),
    .solved_o       (solved_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

// File: src/wfe_checker.sv
// ----------------------------------------------------------------------------
// wfe_checker
// Port-level checks on result beats of the flip engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wfe_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [wfe_pkg::CMD_W-1:0]      cmd_i,
  input logic [wfe_pkg::CIDX_W-1:0]     clause_index_i,
  input logic [wfe_pkg::SLOT_W-1:0]     slot_i,
  input logic [wfe_pkg::VAR_W-1:0]      variable_i,
  input logic                           negated_i,
  input logic                           bit_value_i,
  input logic [wfe_pkg::PICK_W-1:0]     rand_pick_i,
  input logic [wfe_pkg::NOISE_W-1:0]    rand_noise_i,
  input logic [wfe_pkg::SLOT_W-1:0]     rand_slot_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [wfe_pkg::VAR_W-1:0]      flipped_var_o,
  input logic                           read_bit_o,
  input logic [wfe_pkg::CCNT_W-1:0]     unsat_count_o,
  input logic                           solved_o,
  input logic                           status_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [wfe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [wfe_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wfe_pkg::*;

  `WFE_ASSERT(a_solved_match, out_valid_o |-> (solved_o == (unsat_count_o == '0)),
    "solved disagrees with unsat count")

  // a full occurrence list only comes from a load, which flips and reads nothing
  `WFE_ASSERT(a_status_excl, (out_valid_o && status_o) |-> (flipped_var_o == '0 && !read_bit_o),
    "status with flip or read data")

  `WFE_ASSERT(a_ranges, out_valid_o |-> (32'(flipped_var_o) <= MAX_VARS && 32'(unsat_count_o) <= MAX_CLAUSES),
    "result field out of range")

  `WFE_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(unsat_count_o) && $stable(flipped_var_o)),
    "stalled result beat changed")

endmodule

bind walksat_flip_engine wfe_checker u_wfe_checker (.*);

`default_nettype wire

// File: verif/tb_walksat_flip_engine.sv
// ----------------------------------------------------------------------------
// tb_walksat_flip_engine
// Self-checking bench for the WalkSAT flip engine. Small random 3-SAT
// instances are loaded, tries are started and scored flips are run. Every
// step is predicted by a local copy of the clause, occurrence and cost state,
// and each result beat is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_walksat_flip_engine;
  import wfe_pkg::*;

  localparam int  HALF       = 6;
  localparam int  ITEM_GOAL  = 1300;
  localparam int  HOLD_AT    = 300;
  localparam int  HOLD_LEN   = 600;
  localparam longint CYCLE_LIMIT = 6_000_000;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [CIDX_W-1:0]  cidx;
    logic [SLOT_W-1:0]  slot;
    logic [VAR_W-1:0]   vnum;
    logic               neg;
    logic               bitv;
    logic [PICK_W-1:0]  pick;
    logic [NOISE_W-1:0] rnoise;
    logic [SLOT_W-1:0]  rslot;
  } step_t;

  typedef struct {
    logic [VAR_W-1:0]  flipped;
    logic              rbit;
    logic [CCNT_W-1:0] unsat;
    logic              solved;
    logic              status;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  step_t              drv = '{default: '0};
  logic               out_valid;
  logic               out_ready = 1'b0;
  verdict_t           got;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  walksat_flip_engine DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (drv.cmd),
    .clause_index_i (drv.cidx),
    .slot_i         (drv.slot),
    .variable_i     (drv.vnum),
    .negated_i      (drv.neg),
    .bit_value_i    (drv.bitv),
    .rand_pick_i    (drv.pick),
    .rand_noise_i   (drv.rnoise),
    .rand_slot_i    (drv.rslot),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .flipped_var_o  (got.flipped),
    .read_bit_o     (got.rbit),
    .unsat_count_o  (got.unsat),
    .solved_o       (got.solved),
    .status_o       (got.status),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #HALF clk_i = 1'b1;
    #HALF clk_i = 1'b0;
  end

  // ---------------- shadow state of the engine ----------------
  logic [VW-1:0] lit_var   [MAX_CLAUSES*LITS_PER_CLAUSE];
  logic          lit_neg   [MAX_CLAUSES*LITS_PER_CLAUSE];
  logic [CW-1:0] occ_cl    [MAX_VARS*MAX_OCCURRENCES];
  logic          occ_neg   [MAX_VARS*MAX_OCCURRENCES];
  int            occ_len   [MAX_VARS];
  logic          assign_bit[MAX_VARS];
  int            true_cnt  [MAX_CLAUSES];
  int            unsat_ids [MAX_CLAUSES];
  int            unsat_len;
  int            sh_clause_count;
  int            sh_noise;

  step_t    pending_q[$];
  verdict_t expect_q[$];
  int errs, n_results, n_pushed, n_flips, n_full, n_solved, n_tries;
  longint cycles;
  bit calm;

  function automatic void unsat_add(int c);
    for (int i = 0; i < unsat_len; i++)
      if (unsat_ids[i] == c) return;
    if (unsat_len >= MAX_CLAUSES) return;
    unsat_ids[unsat_len] = c;
    unsat_len++;
  endfunction

  function automatic void unsat_drop(int c);
    for (int i = 0; i < unsat_len; i++) begin
      if (unsat_ids[i] == c) begin
        unsat_ids[i] = unsat_ids[unsat_len-1];
        unsat_len--;
        return;
      end
    end
  endfunction

  function automatic bit lit_on(int v, logic n);
    return assign_bit[v] ^ n;
  endfunction

  function automatic verdict_t walk_step(step_t s);
    verdict_t r;
    bit ok;
    int v, n, cl, best, bmin, mmax, brk, mk, c, cost, idx;
    r = '{default: '0};
    ok = s.vnum >= 1 && s.vnum <= MAX_VARS;
    case (s.cmd)
      CMD_LOAD: begin
        if (ok && s.slot < LITS_PER_CLAUSE) begin
          v = s.vnum - 1;
          idx = s.cidx * LITS_PER_CLAUSE + s.slot;
          lit_var[idx] = v;
          lit_neg[idx] = s.neg;
          if (occ_len[v] >= MAX_OCCURRENCES) begin
            r.status = 1'b1;
            n_full++;
          end else begin
            occ_cl[v*MAX_OCCURRENCES + occ_len[v]] = s.cidx;
            occ_neg[v*MAX_OCCURRENCES + occ_len[v]] = s.neg;
            occ_len[v]++;
          end
        end
      end
      CMD_SET: if (ok) assign_bit[s.vnum-1] = s.bitv;
      CMD_START: begin
        n = sh_clause_count > MAX_CLAUSES ? MAX_CLAUSES : sh_clause_count;
        for (int i = 0; i < MAX_CLAUSES; i++) true_cnt[i] = 0;
        unsat_len = 0;
        for (c = 0; c < n; c++) begin
          cost = 0;
          for (int l = 0; l < LITS_PER_CLAUSE; l++)
            if (lit_on(lit_var[c*LITS_PER_CLAUSE+l], lit_neg[c*LITS_PER_CLAUSE+l])) cost++;
          true_cnt[c] = cost;
          if (cost == 0) unsat_add(c);
        end
        n_tries++;
      end
      CMD_FLIP: begin
        if (unsat_len != 0) begin
          cl = unsat_ids[s.pick % unsat_len];
          best = 0; bmin = 0; mmax = 0;
          for (int l = 0; l < LITS_PER_CLAUSE; l++) begin
            v = lit_var[cl*LITS_PER_CLAUSE+l];
            brk = 0; mk = 0;
            for (int k = 0; k < occ_len[v]; k++) begin
              cost = true_cnt[occ_cl[v*MAX_OCCURRENCES+k]];
              if (lit_on(v, occ_neg[v*MAX_OCCURRENCES+k])) begin
                if (cost == 1) brk++;
              end else if (cost == 0) mk++;
            end
            if (l == 0 || brk < bmin || (brk == bmin && mk > mmax)) begin
              bmin = brk; mmax = mk; best = v;
            end
          end
          if (s.rnoise < sh_noise)
            best = lit_var[cl*LITS_PER_CLAUSE + (s.rslot % LITS_PER_CLAUSE)];
          for (int k = 0; k < occ_len[best]; k++) begin
            c = occ_cl[best*MAX_OCCURRENCES+k];
            if (lit_on(best, occ_neg[best*MAX_OCCURRENCES+k])) begin
              if (true_cnt[c] == 1) unsat_add(c);
              if (true_cnt[c] > 0) true_cnt[c]--;
            end else begin
              if (true_cnt[c] == 0) unsat_drop(c);
              if (true_cnt[c] < LITS_PER_CLAUSE) true_cnt[c]++;
            end
          end
          assign_bit[best] = ~assign_bit[best];
          r.flipped = best + 1;
          n_flips++;
        end
      end
      CMD_READ: if (ok) r.rbit = assign_bit[s.vnum-1];
      default: ;
    endcase
    r.unsat  = unsat_len;
    r.solved = unsat_len == 0;
    return r;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expect_q.push_back(walk_step(drv));
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
          drv      <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  int hold_left;
  bit hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (got.solved) n_solved++;
        if (expect_q.size() == 0) begin
          $error("result beat with nothing expected");
          errs++;
        end else begin
          e = expect_q.pop_front();
          if (got.flipped !== e.flipped) begin
            $error("flipped_var exp %0d got %0d", e.flipped, got.flipped); errs++;
          end
          if (got.rbit !== e.rbit) begin
            $error("read_bit exp %0d got %0d", e.rbit, got.rbit); errs++;
          end
          if (got.unsat !== e.unsat) begin
            $error("unsat_count exp %0d got %0d", e.unsat, got.unsat); errs++;
          end
          if (got.solved !== e.solved) begin
            $error("solved exp %0d got %0d", e.solved, got.solved); errs++;
          end
          if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status); errs++;
          end
        end
      end
      // one long back-pressure stretch so the input side stalls
      if (!hold_done && n_results >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(99) >= 35;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    calm = n_results >= 500 && n_results < 700;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic step_t any_step(logic [CMD_W-1:0] cmd);
    step_t s;
    s.cmd    = cmd;
    s.cidx   = $urandom;
    s.slot   = $urandom;
    s.vnum   = $urandom;
    s.neg    = $urandom;
    s.bitv   = $urandom;
    s.pick   = $urandom;
    s.rnoise = $urandom;
    s.rslot  = $urandom;
    return s;
  endfunction

  task automatic push(step_t s);
    pending_q.push_back(s);
    n_pushed++;
  endtask

  task automatic put(logic [CMD_W-1:0] cmd, int cidx, int slot, int vnum, bit neg, bit bitv);
    step_t s;
    s = any_step(cmd);
    s.cidx = cidx; s.slot = slot; s.vnum = vnum; s.neg = neg; s.bitv = bitv;
    push(s);
  endtask

  task automatic flip_step(int pick, int rnoise, int rslot);
    step_t s;
    s = any_step(CMD_FLIP);
    s.pick = pick; s.rnoise = rnoise; s.rslot = rslot;
    push(s);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid || expect_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(wfe_cfg_e idx, int data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CFG_CLAUSE_COUNT) sh_clause_count = data & 'h1FFF;
    else sh_noise = data & 'h3FF;
    cfg_valid <= 1'b0;
  endtask

  // ignored or harmless beats: bad loads, unknown codes, out-of-range variables
  task automatic junk_step();
    step_t s;
    s = any_step(CMD_LOAD);
    case ($urandom_range(4))
      0: s.slot = 2'd3;
      1: s.vnum = 0;
      2: s.vnum = $urandom_range(2047, MAX_VARS + 1);
      3: s.cmd = CMD_READ + $urandom_range(3, 1);
      default: begin
        s.cmd  = $urandom_range(1) ? CMD_SET : CMD_READ;
        s.vnum = $urandom_range(1) ? 0 : $urandom_range(2047, MAX_VARS + 1);
      end
    endcase
    push(s);
  endtask

  task automatic build_instance(int ncl, int base, int width, int nflips);
    step_t s;
    for (int v = base; v < base + width; v++) put(CMD_SET, 0, 0, v, 0, $urandom);
    for (int c = 0; c < ncl; c++)
      for (int l = 0; l < LITS_PER_CLAUSE; l++)
        put(CMD_LOAD, c, l, base + $urandom_range(width - 1), $urandom, 0);
    put(CMD_START, 0, 0, 0, 0, 0);
    for (int f = 0; f < nflips; f++) begin
      flip_step($urandom, $urandom_range(1023), $urandom_range(3));
      if ($urandom_range(5) == 0) put(CMD_READ, 0, 0, base + $urandom_range(width - 1), 0, 0);
      if ($urandom_range(9) == 0) junk_step();
      if ($urandom_range(29) == 0) put(CMD_START, 0, 0, 0, 0, 0);
    end
  endtask

  initial begin
    int ncl, width, base, phase;
    unsat_len = 0;
    sh_clause_count = 1;
    sh_noise = 0;
    for (int i = 0; i < MAX_VARS; i++) begin
      occ_len[i] = 0;
      assign_bit[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening
    put(CMD_READ, 0, 0, 1, 0, 0);
    put(CMD_READ, 0, 0, MAX_VARS, 0, 0);
    put(CMD_SET, 0, 0, MAX_VARS, 0, 1);
    put(CMD_READ, 0, 0, MAX_VARS, 0, 0);
    put(CMD_SET, 0, 0, 0, 0, 1);
    put(CMD_SET, 0, 0, 2047, 0, 1);
    put(CMD_READ, 0, 0, 2047, 0, 0);
    put(CMD_READ, 0, 0, 0, 0, 0);
    flip_step(16'hFFFF, 1023, 3);                   // nothing unsatisfied yet
    put(CMD_LOAD, 0, 0, 1, 0, 0);
    put(CMD_LOAD, 0, 1, MAX_VARS, 1, 0);
    put(CMD_LOAD, 0, 2, 2, 0, 0);
    put(CMD_LOAD, 5, 3, 3, 1, 0);
    put(CMD_LOAD, 5, 1, 0, 1, 0);
    put(CMD_LOAD, 5, 1, MAX_VARS + 1, 1, 0);
    put(CMD_LOAD, MAX_CLAUSES - 1, 2, MAX_VARS, 1, 0);
    for (int k = 1; k <= 3; k++) put(CMD_READ + k, 0, 0, 1, 0, 0);
    put(CMD_START, 0, 0, 0, 0, 0);
    flip_step(16'hFFFF, 0, 3);
    flip_step(0, 1023, 3);
    put(CMD_READ, 0, 0, 1, 0, 0);
    put(CMD_START, 0, 0, 0, 0, 0);
    flip_step(16'h8000, 512, 0);

    // register extremes, then an empty clause set
    wait_idle();
    cfg_write(CFG_CLAUSE_COUNT, 13'h1FFF);
    cfg_write(CFG_NOISE, 13'h1FFF);
    cfg_write(CFG_CLAUSE_COUNT, 0);
    put(CMD_START, 0, 0, 0, 0, 0);
    flip_step($urandom, 0, 0);
    put(CMD_READ, 0, 0, 1, 0, 0);

    phase = 0;
    while (n_pushed < ITEM_GOAL) begin
      wait_idle();
      ncl   = ($urandom_range(5) == 0) ? 1 : $urandom_range(30, 2);
      width = ($urandom_range(6) == 0) ? 2 : $urandom_range(24, 3);   // narrow fills lists
      base  = $urandom_range(MAX_VARS - width + 1, 1);
      if (phase % 5 == 3) cfg_write(CFG_CLAUSE_COUNT, MAX_CLAUSES);   // saturating value
      cfg_write(CFG_CLAUSE_COUNT, ncl);
      case (phase % 4)
        0: cfg_write(CFG_NOISE, 0);
        1: cfg_write(CFG_NOISE, 1000);
        2: cfg_write(CFG_NOISE, $urandom_range(700));
        default: cfg_write(CFG_NOISE, $urandom_range(1023));
      endcase
      build_instance(ncl, base, width, $urandom_range(40, 10));
      phase++;
    end

    wait_idle();
    repeat (200) @(posedge clk_i);
    $display("covered %0d beats, %0d instances, %0d tries, %0d flips", n_results, phase,
             n_tries, n_flips);
    $display("%0d full-list drops, %0d solved answers", n_full, n_solved);
    if (errs == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
